// ===== rtl/mfp_pkg.sv =====
// shared constants, codes and types for the metric frame parser
`timescale 1ns / 1ps
package mfp_pkg;

   // frame layout limits
   localparam int METRIC_MAX = 64;
   localparam int ID_MAX     = 64;
   localparam int HASH_BYTES  = 32;
   localparam int COUNT_BYTES = 4;
   localparam int VALUE_BYTES = 8;

   // field widths
   localparam int DATA_W   = 8;
   localparam int KIND_W   = 3;
   localparam int POS_W    = 6;
   localparam int NUM_W    = 6;
   localparam int VALUE_W  = 64;
   localparam int IDLEN_W  = 6;
   localparam int COUNT_W  = 7;
   localparam int ERR_W    = 3;
   localparam int ACCUM_W  = 32;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_CODE_PRESENT     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CODE_UNAVAILABLE = 1'd1;
   localparam logic [CSR_DATA_W-1:0]  CODE_PRESENT_RESET     = 8'd0;
   localparam logic [CSR_DATA_W-1:0]  CODE_UNAVAILABLE_RESET = 8'd1;

   // field kind codes
   localparam logic [KIND_W-1:0] KIND_HASH    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_COUNT   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_IDLEN   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_IDCHAR  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_STATE   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_VALUE   = 3'd5;
   localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd6;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE        = 3'd0;
   localparam logic [ERR_W-1:0] ERR_TRUNCATED   = 3'd1;
   localparam logic [ERR_W-1:0] ERR_COUNT_LARGE = 3'd2;
   localparam logic [ERR_W-1:0] ERR_BAD_IDLEN   = 3'd3;
   localparam logic [ERR_W-1:0] ERR_BAD_STATE   = 3'd4;
   localparam logic [ERR_W-1:0] ERR_UNAVAIL_NZ  = 3'd5;
   localparam logic [ERR_W-1:0] ERR_TRAILING    = 3'd6;

   // parse phase, one-hot
   typedef enum logic [6:0] {
      PH_HASH   = 7'b0000001,
      PH_COUNT  = 7'b0000010,
      PH_IDLEN  = 7'b0000100,
      PH_IDCHAR = 7'b0001000,
      PH_STATE  = 7'b0010000,
      PH_VALUE  = 7'b0100000,
      PH_END    = 7'b1000000
   } phase_type;

   // one result item
   typedef struct packed {
      logic [KIND_W-1:0]  field_kind;
      logic [POS_W-1:0]   field_position;
      logic [NUM_W-1:0]   metric_number;
      logic [DATA_W-1:0]  byte_out;
      logic               record_done;
      logic               metric_present;
      logic [VALUE_W-1:0] metric_value;
      logic [IDLEN_W-1:0] id_length;
      logic [COUNT_W-1:0] metric_count;
      logic               frame_done;
      logic               frame_ok;
      logic [ERR_W-1:0]   error_code;
   } rsp_payload_type;

endpackage

// ===== rtl/mfp_if.sv =====
// valid/ready channel interfaces for the request and result items
`timescale 1ns / 1ps
interface mfp_req_if import mfp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface mfp_rsp_if import mfp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  field_kind;
   logic [POS_W-1:0]   field_position;
   logic [NUM_W-1:0]   metric_number;
   logic [DATA_W-1:0]  byte_out;
   logic               record_done;
   logic               metric_present;
   logic [VALUE_W-1:0] metric_value;
   logic [IDLEN_W-1:0] id_length;
   logic [COUNT_W-1:0] metric_count;
   logic               frame_done;
   logic               frame_ok;
   logic [ERR_W-1:0]   error_code;

   modport source (output valid, field_kind, field_position, metric_number, byte_out,
                   record_done, metric_present, metric_value, id_length, metric_count,
                   frame_done, frame_ok, error_code, input ready);
   modport sink   (input valid, field_kind, field_position, metric_number, byte_out,
                   record_done, metric_present, metric_value, id_length, metric_count,
                   frame_done, frame_ok, error_code, output ready);
endinterface

// ===== rtl/metric_frame_parser_top.sv =====
// metric frame parser: byte-wise classification and checking of a metric frame
`timescale 1ns / 1ps
// Usage:
//   req_chan carries one frame byte per item with last_byte set on the final byte.
//   rsp_chan returns exactly one result item per request item, in order: the byte's
//   field kind and position, record and frame verdicts.
//   csr_* writes the two state codes (index 0 present, index 1 unavailable); write
//   only while no item is in flight.
// Path: a taken request item loads the input register; the parse step sits between
//   it and the result register, which takes the parse result when it is empty or
//   rsp_chan.ready is high.
// Throughput: one item per cycle unless rsp_chan stalls; the whole parse step for a
//   byte is a single pass of shallow logic, so a new item is accepted every cycle.
// Reset: synchronous; clears the parse state, empties both registers and loads
//   code_present = 0, code_unavailable = 1.
// Stall: when rsp_chan.ready is low the result register holds, the input register
//   still takes one more item, and req_chan.ready drops once both are full.
// After the last byte of a frame the parse state returns to its start, so the
//   next byte begins a new frame; the code registers are kept.
module metric_frame_parser_top import mfp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   mfp_req_if.sink                req_chan,
   mfp_rsp_if.source              rsp_chan,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // configuration registers
   logic [CSR_DATA_W-1:0] code_present_ff, code_present_in;
   logic [CSR_DATA_W-1:0] code_unavail_ff, code_unavail_in;

   // input register
   logic              s1_valid_ff, s1_valid_in;
   logic [DATA_W-1:0] s1_byte_ff, s1_byte_in;
   logic              s1_last_ff, s1_last_in;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   // parse state
   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   bif_ff, bif_in;
   logic [ACCUM_W-1:0] count_ff, count_in;
   logic               count_known_ff, count_known_in;
   logic [COUNT_W-1:0] metrics_left_ff, metrics_left_in;
   logic [NUM_W-1:0]   record_ff, record_in;
   logic [IDLEN_W-1:0] cur_len_ff, cur_len_in;
   logic               present_ff, present_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [ERR_W-1:0]   error_ff, error_in;

   // handshake
   logic req_take;
   logic out_load;
   logic advance;

   assign out_load = !rsp_valid_ff || rsp_chan.ready;
   assign advance  = s1_valid_ff && out_load;
   assign req_chan.ready = !s1_valid_ff || out_load;
   assign req_take = req_chan.valid && req_chan.ready;

   // configuration writes
   always_comb begin
      code_present_in = code_present_ff;
      code_unavail_in = code_unavail_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CODE_PRESENT:     code_present_in = csr_write_data;
            CSR_CODE_UNAVAILABLE: code_unavail_in = csr_write_data;
         endcase
      end
   end

   // input and output register control
   always_comb begin
      s1_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      s1_byte_in   = req_take ? req_chan.data_byte : s1_byte_ff;
      s1_last_in   = req_take ? req_chan.last_byte : s1_last_ff;
      rsp_valid_in = out_load ? s1_valid_ff : rsp_valid_ff;
   end

   // parse step for the byte in the input register
   always_comb begin
      phase_in        = phase_ff;
      bif_in          = bif_ff;
      count_in        = count_ff;
      count_known_in  = count_known_ff;
      metrics_left_in = metrics_left_ff;
      record_in       = record_ff;
      cur_len_in      = cur_len_ff;
      present_in      = present_ff;
      value_in        = value_ff;
      error_in        = error_ff;

      rsp_in                = '0;
      rsp_in.field_kind     = KIND_IGNORED;
      rsp_in.byte_out       = s1_byte_ff;

      unique case (phase_ff)
         PH_HASH: begin
            rsp_in.field_kind     = KIND_HASH;
            rsp_in.field_position = bif_ff;
            if (bif_ff == POS_W'(HASH_BYTES - 1)) begin
               bif_in   = '0;
               phase_in = PH_COUNT;
            end else begin
               bif_in = bif_ff + 1'b1;
            end
         end
         PH_COUNT: begin
            rsp_in.field_kind     = KIND_COUNT;
            rsp_in.field_position = bif_ff;
            count_in = {count_ff[ACCUM_W-DATA_W-1:0], s1_byte_ff};
            if (bif_ff == POS_W'(COUNT_BYTES - 1)) begin
               bif_in         = '0;
               count_known_in = 1'b1;
               if (count_in > ACCUM_W'(METRIC_MAX)) begin
                  error_in = ERR_COUNT_LARGE;
                  phase_in = PH_END;
               end else begin
                  metrics_left_in = count_in[COUNT_W-1:0];
                  phase_in = (count_in == '0) ? PH_END : PH_IDLEN;
               end
            end else begin
               bif_in = bif_ff + 1'b1;
            end
         end
         PH_IDLEN: begin
            rsp_in.field_kind    = KIND_IDLEN;
            rsp_in.metric_number = record_ff;
            if (s1_byte_ff == '0 || {1'b0, s1_byte_ff} >= (DATA_W + 1)'(ID_MAX)) begin
               error_in = ERR_BAD_IDLEN;
               phase_in = PH_END;
            end else begin
               cur_len_in       = s1_byte_ff[IDLEN_W-1:0];
               rsp_in.id_length = s1_byte_ff[IDLEN_W-1:0];
               bif_in           = '0;
               phase_in         = PH_IDCHAR;
            end
         end
         PH_IDCHAR: begin
            rsp_in.field_kind     = KIND_IDCHAR;
            rsp_in.metric_number  = record_ff;
            rsp_in.id_length      = cur_len_ff;
            rsp_in.field_position = bif_ff;
            if (POS_W'(bif_ff + 1'b1) == cur_len_ff) begin
               bif_in   = '0;
               phase_in = PH_STATE;
            end else begin
               bif_in = bif_ff + 1'b1;
            end
         end
         PH_STATE: begin
            rsp_in.field_kind    = KIND_STATE;
            rsp_in.metric_number = record_ff;
            rsp_in.id_length     = cur_len_ff;
            // a bad state is held until the value bytes have all arrived
            priority if (s1_byte_ff == code_present_ff) begin
               present_in = 1'b1;
            end else if (s1_byte_ff == code_unavail_ff) begin
               present_in = 1'b0;
            end else begin
               error_in = ERR_BAD_STATE;
            end
            value_in = '0;
            bif_in   = '0;
            phase_in = PH_VALUE;
         end
         PH_VALUE: begin
            rsp_in.field_kind     = KIND_VALUE;
            rsp_in.metric_number  = record_ff;
            rsp_in.id_length      = cur_len_ff;
            rsp_in.field_position = bif_ff;
            value_in = {value_ff[VALUE_W-DATA_W-1:0], s1_byte_ff};
            if (bif_ff == POS_W'(VALUE_BYTES - 1)) begin
               bif_in = '0;
               if (error_ff != ERR_NONE) begin
                  phase_in = PH_END;
               end else if (!present_ff && value_in != '0) begin
                  error_in = ERR_UNAVAIL_NZ;
                  phase_in = PH_END;
               end else begin
                  rsp_in.record_done    = 1'b1;
                  rsp_in.metric_present = present_ff;
                  rsp_in.metric_value   = value_in;
                  record_in       = record_ff + 1'b1;
                  metrics_left_in = metrics_left_ff - 1'b1;
                  phase_in = (metrics_left_ff == COUNT_W'(1)) ? PH_END : PH_IDLEN;
               end
            end else begin
               bif_in = bif_ff + 1'b1;
            end
         end
         // frame ended or error seen: bytes are tagged ignored; after a clean end they set ERR_TRAILING
         default: begin
            if (error_ff == ERR_NONE) begin
               error_in = ERR_TRAILING;
            end
         end
      endcase

      // declared count, saturated
      if (count_known_in) begin
         rsp_in.metric_count = (|count_in[ACCUM_W-1:COUNT_W]) ? '1 : count_in[COUNT_W-1:0];
      end

      // frame verdict on the last byte, then back to the frame start
      if (s1_last_ff) begin
         rsp_in.frame_done = 1'b1;
         rsp_in.error_code = (phase_in != PH_END) ? ERR_TRUNCATED : error_in;
         rsp_in.frame_ok   = (rsp_in.error_code == ERR_NONE);
         phase_in        = PH_HASH;
         bif_in          = '0;
         count_in        = '0;
         count_known_in  = 1'b0;
         metrics_left_in = '0;
         record_in       = '0;
         cur_len_in      = '0;
         present_in      = 1'b0;
         value_in        = '0;
         error_in        = ERR_NONE;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         code_present_ff <= CODE_PRESENT_RESET;
         code_unavail_ff <= CODE_UNAVAILABLE_RESET;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         phase_ff        <= PH_HASH;
         bif_ff          <= '0;
         count_ff        <= '0;
         count_known_ff  <= 1'b0;
         metrics_left_ff <= '0;
         record_ff       <= '0;
         cur_len_ff      <= '0;
         present_ff      <= 1'b0;
         value_ff        <= '0;
         error_ff        <= ERR_NONE;
      end else begin
         code_present_ff <= code_present_in;
         code_unavail_ff <= code_unavail_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (advance) begin
            phase_ff        <= phase_in;
            bif_ff          <= bif_in;
            count_ff        <= count_in;
            count_known_ff  <= count_known_in;
            metrics_left_ff <= metrics_left_in;
            record_ff       <= record_in;
            cur_len_ff      <= cur_len_in;
            present_ff      <= present_in;
            value_ff        <= value_in;
            error_ff        <= error_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      s1_last_ff <= s1_last_in;
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // result channel
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.field_kind     = rsp_ff.field_kind;
   assign rsp_chan.field_position = rsp_ff.field_position;
   assign rsp_chan.metric_number  = rsp_ff.metric_number;
   assign rsp_chan.byte_out       = rsp_ff.byte_out;
   assign rsp_chan.record_done    = rsp_ff.record_done;
   assign rsp_chan.metric_present = rsp_ff.metric_present;
   assign rsp_chan.metric_value   = rsp_ff.metric_value;
   assign rsp_chan.id_length      = rsp_ff.id_length;
   assign rsp_chan.metric_count   = rsp_ff.metric_count;
   assign rsp_chan.frame_done     = rsp_ff.frame_done;
   assign rsp_chan.frame_ok       = rsp_ff.frame_ok;
   assign rsp_chan.error_code     = rsp_ff.error_code;

endmodule
